@@ src/msd_pkg.sv @@
// shared types and constants for the mouse shake detector
package msd_pkg;

   localparam int POS_W    = 16;
   localparam int DELTA_W  = 17;
   localparam int COUNT_W  = 8;
   localparam int TICKS_W  = 24;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;
   localparam int REG_IDX_W = 3;

   localparam logic OP_MOVE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [REG_IDX_W-1:0] REG_VIEW_LEFT   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_VIEW_TOP    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_VIEW_RIGHT  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_VIEW_BOTTOM = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_THRESHOLD   = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_CANCEL      = 3'd5;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

   localparam logic signed [POS_W-1:0] RST_VIEW_LEFT   = 16'sd0;
   localparam logic signed [POS_W-1:0] RST_VIEW_TOP    = 16'sd0;
   localparam logic signed [POS_W-1:0] RST_VIEW_RIGHT  = 16'sd32767;
   localparam logic signed [POS_W-1:0] RST_VIEW_BOTTOM = 16'sd32767;
   localparam logic [COUNT_W-1:0]      RST_THRESHOLD   = 8'd4;
   localparam logic [TICKS_W-1:0]      RST_CANCEL      = 24'd500000;

   typedef struct packed {
      logic signed [POS_W-1:0] view_left;
      logic signed [POS_W-1:0] view_top;
      logic signed [POS_W-1:0] view_right;
      logic signed [POS_W-1:0] view_bottom;
      logic [COUNT_W-1:0]      count_threshold;
      logic [TICKS_W-1:0]      cancel_ticks;
   } cfg_type;

   typedef struct packed {
      logic move;
      logic tick;
   } ctl_type;

   typedef struct packed {
      logic timer_active;
      logic count_zero;
   } track_status_type;

endpackage

@@ src/msd_csr.sv @@
// configuration registers with apb-style access
module msd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [msd_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [msd_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [msd_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready,
   output msd_pkg::cfg_type              cfg
);

   msd_pkg::cfg_type cfg_ff;
   msd_pkg::cfg_type cfg_in;
   logic [msd_pkg::REG_IDX_W-1:0] reg_idx;
   logic wr_en;

   assign reg_idx    = csr_paddr[msd_pkg::CSR_AW-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            msd_pkg::REG_VIEW_LEFT:   cfg_in.view_left   = csr_pwdata[15:0];
            msd_pkg::REG_VIEW_TOP:    cfg_in.view_top    = csr_pwdata[15:0];
            msd_pkg::REG_VIEW_RIGHT:  cfg_in.view_right  = csr_pwdata[15:0];
            msd_pkg::REG_VIEW_BOTTOM: cfg_in.view_bottom = csr_pwdata[15:0];
            msd_pkg::REG_THRESHOLD:   cfg_in.count_threshold = csr_pwdata[7:0];
            msd_pkg::REG_CANCEL:      cfg_in.cancel_ticks    = csr_pwdata[23:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         msd_pkg::REG_VIEW_LEFT:   csr_prdata = {16'd0, cfg_ff.view_left};
         msd_pkg::REG_VIEW_TOP:    csr_prdata = {16'd0, cfg_ff.view_top};
         msd_pkg::REG_VIEW_RIGHT:  csr_prdata = {16'd0, cfg_ff.view_right};
         msd_pkg::REG_VIEW_BOTTOM: csr_prdata = {16'd0, cfg_ff.view_bottom};
         msd_pkg::REG_THRESHOLD:   csr_prdata = {24'd0, cfg_ff.count_threshold};
         msd_pkg::REG_CANCEL:      csr_prdata = {8'd0, cfg_ff.cancel_ticks};
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.view_left       <= msd_pkg::RST_VIEW_LEFT;
         cfg_ff.view_top        <= msd_pkg::RST_VIEW_TOP;
         cfg_ff.view_right      <= msd_pkg::RST_VIEW_RIGHT;
         cfg_ff.view_bottom     <= msd_pkg::RST_VIEW_BOTTOM;
         cfg_ff.count_threshold <= msd_pkg::RST_THRESHOLD;
         cfg_ff.cancel_ticks    <= msd_pkg::RST_CANCEL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ src/msd_window.sv @@
// view filter, delta window and moving sums
module msd_window #(
   parameter int WINDOW = 8,
   parameter int SUM_W  = 20
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 adv,
   input  logic                                 in_valid,
   input  logic                                 in_opcode,
   input  logic signed [msd_pkg::POS_W-1:0]     in_x,
   input  logic signed [msd_pkg::POS_W-1:0]     in_y,
   input  msd_pkg::cfg_type                     cfg,
   output msd_pkg::ctl_type                     a_ctl,
   output logic signed [SUM_W-1:0]              a_sum_x,
   output logic signed [SUM_W-1:0]              a_sum_y,
   output logic signed [SUM_W-1:0]              a_prev_x,
   output logic signed [SUM_W-1:0]              a_prev_y
);

   logic signed [msd_pkg::DELTA_W-1:0] win_x_ff [WINDOW];
   logic signed [msd_pkg::DELTA_W-1:0] win_y_ff [WINDOW];
   logic signed [msd_pkg::DELTA_W-1:0] win_x_in [WINDOW];
   logic signed [msd_pkg::DELTA_W-1:0] win_y_in [WINDOW];
   logic signed [SUM_W-1:0] sum_x_ff, sum_y_ff, sum_x_in, sum_y_in;
   logic signed [msd_pkg::POS_W-1:0] last_x_ff, last_y_ff;
   logic signed [msd_pkg::POS_W-1:0] view_left, view_top, view_right, view_bottom;
   logic signed [msd_pkg::DELTA_W-1:0] dx, dy;
   logic in_rect, is_move, is_tick;
   msd_pkg::ctl_type a_ctl_ff;
   logic signed [SUM_W-1:0] a_sum_x_ff, a_sum_y_ff, a_prev_x_ff, a_prev_y_ff;

   assign view_left   = cfg.view_left;
   assign view_top    = cfg.view_top;
   assign view_right  = cfg.view_right;
   assign view_bottom = cfg.view_bottom;

   always_comb begin
      in_rect = (in_x >= view_left) && (in_x <= view_right) &&
                (in_y >= view_top) && (in_y <= view_bottom);
      is_move = in_valid && (in_opcode == msd_pkg::OP_MOVE) && in_rect;
      is_tick = in_valid && (in_opcode == msd_pkg::OP_TICK);
      dx = msd_pkg::DELTA_W'(in_x) - msd_pkg::DELTA_W'(last_x_ff);
      dy = msd_pkg::DELTA_W'(in_y) - msd_pkg::DELTA_W'(last_y_ff);
      sum_x_in = sum_x_ff - SUM_W'(win_x_ff[0]) + SUM_W'(dx);
      sum_y_in = sum_y_ff - SUM_W'(win_y_ff[0]) + SUM_W'(dy);
      for (int i = 0; i < WINDOW - 1; i++) begin
         win_x_in[i] = win_x_ff[i+1];
         win_y_in[i] = win_y_ff[i+1];
      end
      win_x_in[WINDOW-1] = dx;
      win_y_in[WINDOW-1] = dy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff  <= '0;
         sum_x_ff  <= '0;
         sum_y_ff  <= '0;
         last_x_ff <= '0;
         last_y_ff <= '0;
         for (int i = 0; i < WINDOW; i++) begin
            win_x_ff[i] <= '0;
            win_y_ff[i] <= '0;
         end
      end else if (adv) begin
         a_ctl_ff.move <= is_move;
         a_ctl_ff.tick <= is_tick;
         if (is_move) begin
            sum_x_ff  <= sum_x_in;
            sum_y_ff  <= sum_y_in;
            last_x_ff <= in_x;
            last_y_ff <= in_y;
            for (int i = 0; i < WINDOW; i++) begin
               win_x_ff[i] <= win_x_in[i];
               win_y_ff[i] <= win_y_in[i];
            end
         end
      end
   end

   // payload of the next stage
   always_ff @(posedge clock) begin
      if (adv) begin
         a_sum_x_ff  <= sum_x_in;
         a_sum_y_ff  <= sum_y_in;
         a_prev_x_ff <= sum_x_ff;
         a_prev_y_ff <= sum_y_ff;
      end
   end

   assign a_ctl    = a_ctl_ff;
   assign a_sum_x  = a_sum_x_ff;
   assign a_sum_y  = a_sum_y_ff;
   assign a_prev_x = a_prev_x_ff;
   assign a_prev_y = a_prev_y_ff;

endmodule

@@ src/msd_dot.sv @@
// products of the new and previous moving sums
module msd_dot #(
   parameter int SUM_W = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  msd_pkg::ctl_type              a_ctl,
   input  logic signed [SUM_W-1:0]       a_sum_x,
   input  logic signed [SUM_W-1:0]       a_sum_y,
   input  logic signed [SUM_W-1:0]       a_prev_x,
   input  logic signed [SUM_W-1:0]       a_prev_y,
   output msd_pkg::ctl_type              b_ctl,
   output logic signed [2*SUM_W-1:0]     prod_x,
   output logic signed [2*SUM_W-1:0]     prod_y
);

   msd_pkg::ctl_type b_ctl_ff;
   logic signed [2*SUM_W-1:0] prod_x_ff, prod_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctl_ff <= '0;
      end else if (adv) begin
         b_ctl_ff <= a_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_x_ff <= a_sum_x * a_prev_x;
         prod_y_ff <= a_sum_y * a_prev_y;
      end
   end

   assign b_ctl  = b_ctl_ff;
   assign prod_x = prod_x_ff;
   assign prod_y = prod_y_ff;

endmodule

@@ src/msd_count.sv @@
// u-turn counter, cancel timer and result register
module msd_count #(
   parameter int SUM_W = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  msd_pkg::ctl_type                    b_ctl,
   input  logic signed [2*SUM_W-1:0]           prod_x,
   input  logic signed [2*SUM_W-1:0]           prod_y,
   input  msd_pkg::cfg_type                    cfg,
   output logic                                rsp_valid,
   output logic [msd_pkg::COUNT_W-1:0]         rsp_shake_count,
   output msd_pkg::track_status_type           status
);

   localparam int DOT_W = 2 * SUM_W + 1;

   logic signed [DOT_W-1:0] dot;
   logic uturn;
   logic [msd_pkg::COUNT_W-1:0] count_ff, count_in, bumped;
   logic [msd_pkg::TICKS_W-1:0] rem_ff, rem_in;
   logic active_ff, active_in;
   logic emit;
   logic rsp_valid_ff;
   logic [msd_pkg::COUNT_W-1:0] rsp_count_ff;

   always_comb begin
      dot       = DOT_W'(prod_x) + DOT_W'(prod_y);
      uturn     = b_ctl.move && dot[DOT_W-1];
      count_in  = count_ff;
      rem_in    = rem_ff;
      active_in = active_ff;
      emit      = 1'b0;
      bumped    = (count_ff == msd_pkg::COUNT_MAX) ? count_ff :
                  count_ff + msd_pkg::COUNT_W'(1);
      if (b_ctl.tick && active_ff) begin
         if (rem_ff <= msd_pkg::TICKS_W'(1)) begin
            rem_in    = '0;
            active_in = 1'b0;
            count_in  = '0;
         end else begin
            rem_in = rem_ff - msd_pkg::TICKS_W'(1);
         end
      end
      if (uturn) begin
         if (count_ff == '0) begin
            rem_in    = cfg.cancel_ticks;
            active_in = 1'b1;
         end
         count_in = bumped;
         emit     = (bumped >= cfg.count_threshold);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rem_ff       <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         active_ff    <= active_in;
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_shake_count     = rsp_count_ff;
   assign status.timer_active = active_ff;
   assign status.count_zero   = (count_ff == '0);

endmodule

@@ src/mouse_shake_detector.sv @@
// mouse shake detector top level
// path: a result item reaches rsp_valid through the input, sum, product and result registers in turn
// throughput: one item per cycle while no held result stalls; input, sum, product and result registers advance together
// a held result stalls the whole pipeline, and req_ready follows the result slot
// reset clears the window, sums, counter, timer, valid bits and restores register defaults
module mouse_shake_detector #(
   parameter int WINDOW = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_opcode,
   input  logic signed [msd_pkg::POS_W-1:0]   req_pos_x,
   input  logic signed [msd_pkg::POS_W-1:0]   req_pos_y,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [msd_pkg::COUNT_W-1:0]        rsp_shake_count,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [msd_pkg::CSR_AW-1:0]         csr_paddr,
   input  logic [msd_pkg::CSR_DW-1:0]         csr_pwdata,
   output logic [msd_pkg::CSR_DW-1:0]         csr_prdata,
   output logic                               csr_pready
);

   localparam int SUM_W = msd_pkg::DELTA_W + $clog2(WINDOW);

   msd_pkg::cfg_type cfg;
   msd_pkg::ctl_type a_ctl, b_ctl;
   msd_pkg::track_status_type status;
   logic adv;
   logic in_valid_ff, in_opcode_ff;
   logic signed [msd_pkg::POS_W-1:0] in_x_ff, in_y_ff;
   logic signed [SUM_W-1:0] a_sum_x, a_sum_y, a_prev_x, a_prev_y;
   logic signed [2*SUM_W-1:0] prod_x, prod_y;

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (adv) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_opcode_ff <= req_opcode;
         in_x_ff      <= req_pos_x;
         in_y_ff      <= req_pos_y;
      end
   end

   msd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   msd_window #(
      .WINDOW (WINDOW),
      .SUM_W  (SUM_W)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (in_valid_ff),
      .in_opcode (in_opcode_ff),
      .in_x      (in_x_ff),
      .in_y      (in_y_ff),
      .cfg       (cfg),
      .a_ctl     (a_ctl),
      .a_sum_x   (a_sum_x),
      .a_sum_y   (a_sum_y),
      .a_prev_x  (a_prev_x),
      .a_prev_y  (a_prev_y)
   );

   msd_dot #(
      .SUM_W (SUM_W)
   ) u_dot (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .a_ctl    (a_ctl),
      .a_sum_x  (a_sum_x),
      .a_sum_y  (a_sum_y),
      .a_prev_x (a_prev_x),
      .a_prev_y (a_prev_y),
      .b_ctl    (b_ctl),
      .prod_x   (prod_x),
      .prod_y   (prod_y)
   );

   msd_count #(
      .SUM_W (SUM_W)
   ) u_count (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .b_ctl           (b_ctl),
      .prod_x          (prod_x),
      .prod_y          (prod_y),
      .cfg             (cfg),
      .rsp_valid       (rsp_valid),
      .rsp_shake_count (rsp_shake_count),
      .status          (status)
   );

`ifndef SYNTH
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> in_valid_ff)
      else $error("accepted item did not reach the input register");

   a_count_needs_timer: assert property (@(posedge clock) disable iff (reset)
      !status.timer_active |-> status.count_zero)
      else $error("u-turn count held without a running cancel timer");

   a_report_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_shake_count != '0) && status.timer_active)
      else $error("shake report with zero count or idle timer");
`endif

endmodule

@@ tb/shake_tb_pkg.sv @@
// scoreboard with the u-turn and cancel-timer predictor for the shake detector bench
`timescale 1ns / 100ps
package shake_tb_pkg;
   import msd_pkg::*;

   localparam int SHAKE_WINDOW = 8;
   localparam int SUM_W = 20;

   class shake_scoreboard;
      logic signed [POS_W-1:0]   view_left, view_top, view_right, view_bottom;
      logic [COUNT_W-1:0]        count_threshold;
      logic [TICKS_W-1:0]        cancel_ticks;
      logic signed [DELTA_W-1:0] win_dx[SHAKE_WINDOW];
      logic signed [DELTA_W-1:0] win_dy[SHAKE_WINDOW];
      logic signed [SUM_W-1:0]   sum_x, sum_y, prev_x, prev_y;
      logic signed [POS_W-1:0]   last_x, last_y;
      logic [COUNT_W-1:0]        uturns;
      logic [TICKS_W-1:0]        timer_left;
      logic                      timer_on;
      logic [COUNT_W-1:0]        counts_due[$];
      int                        errors, items, ignored, reports, expiries, peak;

      function new();
         view_left = RST_VIEW_LEFT;
         view_top = RST_VIEW_TOP;
         view_right = RST_VIEW_RIGHT;
         view_bottom = RST_VIEW_BOTTOM;
         count_threshold = RST_THRESHOLD;
         cancel_ticks = RST_CANCEL;
         foreach (win_dx[i]) begin
            win_dx[i] = '0;
            win_dy[i] = '0;
         end
         sum_x = '0;
         sum_y = '0;
         prev_x = '0;
         prev_y = '0;
         last_x = '0;
         last_y = '0;
         uturns = '0;
         timer_left = '0;
         timer_on = 1'b0;
         errors = 0;
         items = 0;
         ignored = 0;
         reports = 0;
         expiries = 0;
         peak = 0;
      endfunction

      function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CSR_DW-1:0] value);
         case (idx)
            REG_VIEW_LEFT: view_left = value[POS_W-1:0];
            REG_VIEW_TOP: view_top = value[POS_W-1:0];
            REG_VIEW_RIGHT: view_right = value[POS_W-1:0];
            REG_VIEW_BOTTOM: view_bottom = value[POS_W-1:0];
            REG_THRESHOLD: count_threshold = value[COUNT_W-1:0];
            REG_CANCEL: cancel_ticks = value[TICKS_W-1:0];
            default: ;
         endcase
      endfunction

      function void track_item(logic op, logic signed [POS_W-1:0] x,
                               logic signed [POS_W-1:0] y);
         logic signed [DELTA_W-1:0] dx, dy;
         logic signed [2*SUM_W:0]   dot;
         int                        i;
         items++;
         if (op == OP_TICK) begin
            if (timer_on) begin
               if (timer_left <= 1) begin
                  timer_left = '0;
                  timer_on = 1'b0;
                  uturns = '0;
                  expiries++;
               end else begin
                  timer_left = timer_left - 1'b1;
               end
            end
            return;
         end
         if (x < view_left || x > view_right || y < view_top || y > view_bottom) begin
            ignored++;
            return;
         end
         dx = x - last_x;
         dy = y - last_y;
         sum_x = sum_x - win_dx[0] + dx;
         sum_y = sum_y - win_dy[0] + dy;
         for (i = 0; i < SHAKE_WINDOW - 1; i++) begin
            win_dx[i] = win_dx[i+1];
            win_dy[i] = win_dy[i+1];
         end
         win_dx[SHAKE_WINDOW-1] = dx;
         win_dy[SHAKE_WINDOW-1] = dy;
         dot = sum_x * prev_x + sum_y * prev_y;
         prev_x = sum_x;
         prev_y = sum_y;
         last_x = x;
         last_y = y;
         if (dot < 0) begin
            if (uturns == 0) begin
               timer_left = cancel_ticks;
               timer_on = 1'b1;
            end
            if (uturns != COUNT_MAX) uturns = uturns + 1'b1;
            if (uturns > peak) peak = uturns;
            if (uturns >= count_threshold) counts_due.push_back(uturns);
         end
      endfunction

      function void check_result(logic [COUNT_W-1:0] got);
         logic [COUNT_W-1:0] want;
         if (counts_due.size() == 0) begin
            errors++;
            $display("%0t: expected no item, got shake_count %0d", $time, got);
            return;
         end
         want = counts_due.pop_front();
         reports++;
         if (got !== want) begin
            errors++;
            $display("%0t: shake_count expected %0d, got %0d", $time, want, got);
         end
      endfunction
   endclass

endpackage

@@ tb/testbench.sv @@
// top-level bench for the mouse shake detector: stimulus, handshakes and run control
`timescale 1ns / 100ps
module testbench;
   import msd_pkg::*;
   import shake_tb_pkg::*;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_opcode = OP_MOVE;
   logic signed [POS_W-1:0]   req_pos_x = '0;
   logic signed [POS_W-1:0]   req_pos_y = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b1;
   logic [COUNT_W-1:0]        rsp_shake_count;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]         csr_paddr = '0;
   logic [CSR_DW-1:0]         csr_pwdata = '0;
   logic [CSR_DW-1:0]         csr_prdata;
   logic                      csr_pready;

   shake_scoreboard           sb;
   bit                        idle_on = 1'b1;
   int                        ph;

   mouse_shake_detector u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_shake_count (rsp_shake_count),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.track_item(req_opcode, req_pos_x, req_pos_y);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_shake_count);
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      #3_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic int rand_pos();
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   function automatic int pick_in(input int lo, input int hi);
      if (lo > hi) return rand_pos();
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic int clamp(input int v, input int lo, input int hi);
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
   endfunction

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [CSR_DW-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_view(input int l, input int t, input int r, input int b);
      csr_write(REG_VIEW_LEFT, l);
      csr_write(REG_VIEW_TOP, t);
      csr_write(REG_VIEW_RIGHT, r);
      csr_write(REG_VIEW_BOTTOM, b);
   endtask

   task automatic send_item(input logic op, input int x, input int y);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 9)) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_pos_x <= x[POS_W-1:0];
      req_pos_y <= y[POS_W-1:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // hold off until every expected report is in and the pipeline has emptied
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.counts_due.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // shakes are short closed loops of points replayed a few rounds
   task automatic run_phase(input int n_items, input int tick_pct, input bit steady);
      int sent, period, amp, cx, cy, j, r, rounds;
      int px[7];
      int py[7];
      sent = 0;
      while (sent < n_items) begin
         if (steady || $urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 3))
               0: period = 3;
               1: period = 5;
               2: period = 6;
               default: period = 7;
            endcase
            if (steady) period = 3;
            if ($urandom_range(0, 9) == 0) amp = $urandom_range(20, 32767);
            else amp = steady ? $urandom_range(20, 80) : $urandom_range(1, 80);
            cx = pick_in(sb.view_left, sb.view_right);
            cy = pick_in(sb.view_top, sb.view_bottom);
            for (j = 0; j < period; j++) begin
               px[j] = clamp(cx + int'($urandom_range(0, 2 * amp)) - amp,
                             sb.view_left, sb.view_right);
               py[j] = clamp(cy + int'($urandom_range(0, 2 * amp)) - amp,
                             sb.view_top, sb.view_bottom);
            end
            rounds = $urandom_range(2, 12);
            for (r = 0; r < rounds && sent < n_items; r++) begin
               for (j = 0; j < period; j++) begin
                  if ($urandom_range(0, 99) < tick_pct) begin
                     send_item(OP_TICK, rand_pos(), rand_pos());
                     sent++;
                  end
                  if (!steady && $urandom_range(0, 19) == 0)
                     send_item(OP_MOVE, rand_pos(), rand_pos());
                  else
                     send_item(OP_MOVE, px[j], py[j]);
                  sent++;
               end
            end
         end else begin
            repeat ($urandom_range(1, 10)) begin
               if ($urandom_range(0, 1))
                  send_item(OP_TICK, rand_pos(), rand_pos());
               else if ($urandom_range(0, 1))
                  send_item(OP_MOVE, rand_pos(), rand_pos());
               else
                  send_item(OP_MOVE, pick_in(sb.view_left, sb.view_right),
                            pick_in(sb.view_top, sb.view_bottom));
               sent++;
            end
         end
      end
   endtask

   initial begin
      int a, b, w;
      sb = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset view: inactive tick, zero dot product, edges and moves outside
      send_item(OP_TICK, 0, 0);
      send_item(OP_MOVE, 0, 0);
      send_item(OP_MOVE, -1, 10);
      send_item(OP_MOVE, 10, -1);
      send_item(OP_MOVE, 32767, 32767);
      send_item(OP_MOVE, 0, 0);
      send_item(OP_MOVE, 32767, 32767);
      send_item(OP_MOVE, 0, 0);
      drain();

      // full range, every u-turn reports, timer expires on first tick
      set_view(-32768, -32768, 32767, 32767);
      csr_write(REG_THRESHOLD, 1);
      csr_write(REG_CANCEL, 0);
      send_item(OP_MOVE, -32768, -32768);
      send_item(OP_MOVE, 32767, 32767);
      send_item(OP_MOVE, -32768, -32768);
      send_item(OP_MOVE, 32767, -32768);
      send_item(OP_MOVE, -32768, 32767);
      send_item(OP_TICK, -1, -1);
      send_item(OP_MOVE, 32767, 32767);
      drain();

      // inverted view ignores everything
      set_view(100, 100, -100, -100);
      send_item(OP_MOVE, 0, 0);
      send_item(OP_MOVE, 150, -150);
      send_item(OP_TICK, 0, 0);
      drain();

      set_view(-50, -50, 50, 50);
      send_item(OP_MOVE, 51, 0);
      send_item(OP_MOVE, 0, 51);
      send_item(OP_MOVE, -51, 0);
      send_item(OP_MOVE, 0, -51);
      send_item(OP_MOVE, 50, 50);
      send_item(OP_MOVE, -50, -50);
      send_item(OP_MOVE, 50, -50);
      drain();

      for (ph = 0; ph < 10; ph++) begin
         idle_on = (ph != 4 && ph != 9);
         case (ph)
            0: begin
               set_view(-32768, -32768, 32767, 32767);
               csr_write(REG_THRESHOLD, 1);
               csr_write(REG_CANCEL, 0);
               run_phase(80, 20, 1'b0);
            end
            1: begin
               // long burst with a timer that never runs out, count saturates
               csr_write(REG_THRESHOLD, 255);
               csr_write(REG_CANCEL, 24'hFFFFFF);
               run_phase(480, 5, 1'b1);
            end
            2: begin
               set_view(RST_VIEW_LEFT, RST_VIEW_TOP, RST_VIEW_RIGHT, RST_VIEW_BOTTOM);
               csr_write(REG_THRESHOLD, 0);
               csr_write(REG_CANCEL, 1);
               run_phase(80, 15, 1'b0);
            end
            9: begin
               set_view(-32768, -32768, 32767, 32767);
               csr_write(REG_THRESHOLD, 2);
               csr_write(REG_CANCEL, 30);
               run_phase(80, 10, 1'b0);
            end
            default: begin
               case ($urandom_range(0, 7))
                  0: begin
                     a = pick_in(-30000, 30000);
                     set_view(a + 1 + int'($urandom_range(0, 99)), -32768, a, 32767);
                  end
                  1, 2: begin
                     a = pick_in(-32768, 32667);
                     b = pick_in(-32768, 32667);
                     w = $urandom_range(0, 100);
                     set_view(a, b, a + w, b + w);
                  end
                  3, 4: set_view(pick_in(-32768, 0), pick_in(-32768, 0),
                                 pick_in(0, 32767), pick_in(0, 32767));
                  default: set_view(-32768, -32768, 32767, 32767);
               endcase
               if ($urandom_range(0, 4) == 0) csr_write(REG_THRESHOLD, $urandom_range(1, 255));
               else csr_write(REG_THRESHOLD, $urandom_range(1, 6));
               if ($urandom_range(0, 4) == 0) csr_write(REG_CANCEL, $urandom_range(0, 24'hFFFFFF));
               else csr_write(REG_CANCEL, $urandom_range(2, 60));
               run_phase(70, $urandom_range(5, 30), 1'b0);
            end
         endcase
         drain();
      end

      $display("covered %0d items, %0d moves outside the view, %0d shake reports checked",
               sb.items, sb.ignored, sb.reports);
      $display("timer expiries %0d, highest u-turn count %0d", sb.expiries, sb.peak);
      if (sb.errors == 0 && sb.counts_due.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
